// ===== rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

  // Reciprocal of ten, scaled by 2^35; (x * RECIP_TEN) >> 35 == x / 10 for all 32-bit x.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIG,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;        // capture a new value
    logic mul;         // form magnitude times reciprocal
    logic dig;         // split off one digit
    logic emit_sign;   // send the minus sign
    logic emit_digit;  // send the next stored digit
  } itoa_cmd_t;

  typedef struct packed {
    logic q_zero;      // quotient of this digit step is zero
    logic neg;         // captured value is negative
    logic out_free;    // output register can take a beat
    logic idx_zero;    // next digit to send is the least significant
  } itoa_sts_t;

endpackage

// ===== rtl/itoa_dp.sv =====
`timescale 1ns / 1ps

module itoa_dp
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  itoa_cmd_t   cmd,
  output itoa_sts_t   sts,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last
);

  logic [31:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [3:0]       dig_r [MAX_DIGITS];
  logic [IDX_W-1:0] ndig_r, ndig_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic [28:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;

  assign quot     = prod_r[RECIP_SHIFT +: 29];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag_r - quot_x10;

  assign sts.q_zero   = (quot == '0);
  assign sts.neg      = neg_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.idx_zero = (rd_idx_r == '0);

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    ndig_nxt      = ndig_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      neg_nxt  = in_value[31];
      mag_nxt  = in_value[31] ? (~in_value + 32'd1) : in_value;
      ndig_nxt = '0;
    end
    if (cmd.mul) begin
      prod_nxt = {32'd0, mag_r} * {32'd0, RECIP_TEN};
    end
    if (cmd.dig) begin
      mag_nxt    = {3'b000, quot};
      ndig_nxt   = ndig_r + 1'b1;
      rd_idx_nxt = ndig_r;
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ASCII_MINUS;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ASCII_ZERO + {4'd0, dig_r[rd_idx_r]};
      out_last_nxt  = (rd_idx_r == '0);
      rd_idx_nxt    = rd_idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    ndig_r     <= ndig_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.dig) begin
      dig_r[ndig_r] <= rem_full[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/itoa_ctrl.sv =====
`timescale 1ns / 1ps

module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  itoa_sts_t sts,
  output itoa_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        cmd.dig = 1'b1;
        if (!sts.q_zero) begin
          state_nxt = ST_MUL;
        end else if (sts.neg) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps

// Converts one signed 32-bit two's complement value per input beat into its
// decimal text, sent as ASCII bytes most significant first: a '-' for a
// negative value, then the magnitude's digits without leading zeros ("0" for
// zero, "-2147483648" for the most negative value); out_tlast marks the final
// character. One value is converted at a time. The digits are split off least
// significant first by a shared divide-by-ten unit (a 32x32 multiply by the
// scaled reciprocal of ten, then a shift-and-subtract for the remainder), which
// takes a multiply step and a digit step per digit; they are then played back
// from a ten-entry digit store at one character per cycle while out_tready is
// high, through a registered output stage. A new value is taken as soon as
// the last character sits in the output register, even while that beat still
// waits for out_tready.
module signed_int_to_decimal_ascii_core
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value (signed)
  // Result stream, one character per beat.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] character
  output logic        out_tlast    // last character of this value's text
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  // Sequence load, digit split and playback.
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold magnitude, reciprocal product, digit store and output register.
  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // Stay busy right after taking a value: at least one digit step follows.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a value was accepted");

  // A minus sign never ends the text.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata == ASCII_MINUS)) |-> !out_tlast)
    else $error("minus sign marked as last character");

  // Every other character is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata != ASCII_MINUS)) |->
      ((out_tdata >= ASCII_ZERO) && (out_tdata <= (ASCII_ZERO + 8'd9))))
    else $error("character out of digit range");

  // Load the first digit in the same cycle the sign beat leaves.
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (out_tdata == ASCII_MINUS)) |=>
      (out_tvalid && (out_tdata != ASCII_MINUS)))
    else $error("no digit beat straight after a minus sign");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Checks the signed-integer-to-decimal-text converter: every value sent in
// is turned into its expected character beats on the side, and each beat that
// leaves the block is matched in order against them. The sender runs in
// random bursts; the receiver stalls in patterns that change as the run goes.
module tb_top;
  import itoa_pkg::ASCII_ZERO;
  import itoa_pkg::ASCII_MINUS;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  char_beat_t  expected_chars[$];
  int          err_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_cnt = 0;

  signed_int_to_decimal_ascii_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Queue the characters that one accepted value must produce.
  task automatic predict_decimal_text(input logic [31:0] value);
    logic        neg;
    logic [31:0] mag;
    logic [7:0]  digits[10];
    int          ndig;
    char_beat_t  beat;
    neg  = value[31];
    mag  = neg ? (~value + 32'd1) : value;
    ndig = 0;
    do begin
      digits[ndig] = ASCII_ZERO + 8'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < 10);
    if (neg) begin
      beat.ch   = ASCII_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      beat.ch   = digits[k];
      beat.last = (k == 0);
      expected_chars.push_back(beat);
    end
  endtask

  // Send one value; hold valid across a burst, drop it for a random gap after.
  task automatic send_value(input logic [31:0] value);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    predict_decimal_text(value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 20)) @(posedge clk);
      else
        repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Hold off the sender until every queued character has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  // Draw a value with a chosen digit count and sign.
  function automatic logic [31:0] value_of_length(input int ndig, input bit neg);
    longint unsigned lo, hi, mag;
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (ndig == 10) hi = neg ? 64'd2147483648 : 64'd2147483647;
    case ($urandom_range(0, 9))
      0:       mag = lo;
      1:       mag = hi;
      default: mag = $urandom_range(32'(hi), 32'(lo));
    endcase
    return neg ? (~32'(mag) + 32'd1) : 32'(mag);
  endfunction

  task automatic test_directed();
    logic [31:0] corner[$];
    corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'h7FFF_FFFF,
               32'h8000_0000, 32'd99, 32'd100, 32'd999_999_999, 32'd1_000_000_000,
               -32'sd1_000_000_000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123_456_789,
               -32'sd987_654_321, 32'd7, -32'sd9, 32'h8000_0001, 32'd2_000_000_000};
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic test_random_lengths(input int count);
    for (int i = 0; i < count; i++)
      send_value(value_of_length($urandom_range(1, 10), $urandom_range(0, 1)));
  endtask

  task automatic test_random_words(input int count);
    for (int i = 0; i < count; i++) begin
      send_value($urandom());
      // Let the output side catch up once, mid-stream.
      if (i == count / 2) wait_drained();
    end
  endtask

  // Receiver: pick a new stall pattern whenever the stall counter runs out; some stretches never stall.
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= 47;
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= stall_cnt[2];
    endcase
  end

  // Match every character beat against the oldest prediction.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h with nothing expected", out_tdata));
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.ch)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    out_tdata, want.ch));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b on character 0x%02h",
                                    out_tlast, want.last, want.ch));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_random_lengths(240);
    wait_drained();
    test_random_words(200);
    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
